FILE: rtl/core/tlnl_pkg.sv
// Shared types and constants for the text line normalize and limit core.
// Used by tlnl_text_buf and text_line_normalize_limit_core; depends on nothing.
`timescale 1ns / 1ps

package tlnl_pkg;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	localparam logic [1:0] REG_MIN_WORDS = 2'd0;
	localparam logic [1:0] REG_MAX_WORDS = 2'd1;
	localparam logic [1:0] REG_MAX_CHARS = 2'd2;

	localparam logic [8:0] MIN_WORDS_RST = 9'd1;
	localparam logic [8:0] MAX_WORDS_RST = 9'd256;
	localparam logic [8:0] MAX_CHARS_RST = 9'd256;

	localparam logic [8:0] COUNT_SAT = 9'd511;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DEL   = 8'h7F;

	typedef struct packed {
		logic even;
		logic odd;
	} buf_we_t;

	function automatic logic is_alnum(input logic [7:0] c);
		is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

FILE: rtl/core/tlnl_text_buf.sv
// Line buffer split into even and odd address banks, so that one beat can store two bytes.
// Each bank has one write port and one registered read port; uses tlnl_pkg.
`timescale 1ns / 1ps

module tlnl_text_buf #(
	parameter int HALF_DEPTH = 128,
	parameter int HA = 7
) (
	input  logic             clk,
	input  tlnl_pkg::buf_we_t we,
	input  logic [HA-1:0]    waddr_even,
	input  logic [7:0]       wdata_even,
	input  logic [HA-1:0]    waddr_odd,
	input  logic [7:0]       wdata_odd,
	input  logic             re,
	input  logic [HA-1:0]    raddr,
	output logic [7:0]       rdata_even,
	output logic [7:0]       rdata_odd
);

	logic [7:0] bank_even [HALF_DEPTH];
	logic [7:0] bank_odd  [HALF_DEPTH];

	always_ff @(posedge clk) begin
		if (we.even) begin
			bank_even[waddr_even] <= wdata_even;
		end
		if (re) begin
			rdata_even <= bank_even[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we.odd) begin
			bank_odd[waddr_odd] <= wdata_odd;
		end
		if (re) begin
			rdata_odd <= bank_odd[raddr];
		end
	end

endmodule

FILE: rtl/core/text_line_normalize_limit_core.sv
// Top level of the text line normalize and limit core: running counters, verdict and read path.
// Depends on tlnl_pkg and tlnl_text_buf.
//
//   channel   signals                                        direction
//   in        in_valid/in_ready, cmd, byte_in, last_byte,
//             read_index                                     input beats
//   out       out_valid/out_ready, kind, line_ok,
//             clean_length, word_count, char_out             result beats
//   cfg       cfg_valid/cfg_ready, cfg_index, cfg_data       register writes
//
// One input beat is taken every cycle unless the output stalls with both stages full; a push
// updates the counters and writes up to two buffer bytes, one in each bank, in the cycle it is accepted.
// A result passes through the stage-one registers, beside the registered buffer read, and
// then the output register. Only reads and last bytes produce results.
// Reset clears counters and valid flags and loads the register defaults at once; the buffer needs no clearing pass.
// A stalled output holds the result stage, and input is refused only when both are full.
`timescale 1ns / 1ps

module text_line_normalize_limit_core #(
	parameter int LINE_MAX = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] byte_in,
	input  logic       last_byte,
	input  logic [7:0] read_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic       line_ok,
	output logic [8:0] clean_length,
	output logic [8:0] word_count,
	output logic [7:0] char_out,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	localparam int AW = $clog2(LINE_MAX);
	localparam int HA = AW - 1;
	localparam int HALF_DEPTH = (LINE_MAX + 1) / 2;
	localparam int CW = $clog2(LINE_MAX + 2);
	localparam int EW = (CW > 9) ? CW : 9;
	localparam int IW = (AW > 8) ? AW : 8;

	logic [8:0] min_words_q, max_words_q, max_chars_q;

	logic [CW-1:0] cc_q, lsp_q, kept_q;
	logic          ps_q, iw_q, done_q;
	logic [8:0]    wt_q, was_q, wal_q;

	logic          v_s1, kind_s1, ok_s1, hit_s1, odd_s1;
	logic [8:0]    len_s1, words_s1;

	logic          out_valid_q, kind_q, ok_q;
	logic [8:0]    len_q, words_q;
	logic [7:0]    char_q;

	logic          out_adv, s1_adv, acc, acc_push, acc_read;
	logic [CW-1:0] lim, cc0, lsp0, cc1, cc2, lsp2, len_v;
	logic          ps0, iw0, ps2, iw2, is_sp, sp_put, ch_put, sp_wr, ch_wr, ok_v;
	logic [8:0]    wt0, was0, wal0, wt2, was2, wal2, words_v, len_sat;
	logic [EW-1:0] len_e;
	logic [IW-1:0] idx_w;

	tlnl_pkg::buf_we_t buf_we;
	logic [HA-1:0] waddr_even, waddr_odd;
	logic [7:0]    wdata_even, wdata_odd, rdata_even, rdata_odd;

	assign cfg_ready = 1'b1;

	assign out_adv  = !out_valid_q || out_ready;
	assign s1_adv   = !v_s1 || out_adv;
	assign in_ready = s1_adv;
	assign acc      = in_valid && in_ready;
	assign acc_push = acc && (cmd == tlnl_pkg::CMD_PUSH);
	assign acc_read = acc && (cmd == tlnl_pkg::CMD_READ);

	always_comb begin
		lim = (EW'(max_chars_q) > EW'(LINE_MAX)) ? CW'(LINE_MAX) : CW'(max_chars_q);

		cc0  = done_q ? '0 : cc_q;
		ps0  = done_q ? 1'b0 : ps_q;
		iw0  = done_q ? 1'b0 : iw_q;
		wt0  = done_q ? '0 : wt_q;
		lsp0 = done_q ? '0 : lsp_q;
		was0 = done_q ? '0 : was_q;
		wal0 = done_q ? '0 : wal_q;

		is_sp  = (byte_in < tlnl_pkg::CHAR_SPACE) || (byte_in == tlnl_pkg::CHAR_DEL) ||
			(byte_in == tlnl_pkg::CHAR_SPACE);
		sp_put = !is_sp && ps0;
		ch_put = !is_sp;

		cc1 = cc0;
		cc2 = cc0;
		ps2 = ps0;
		iw2 = iw0;
		wt2 = wt0;
		lsp2 = lsp0;
		was2 = was0;
		wal2 = wal0;

		if (is_sp) begin
			ps2 = ps0 || (cc0 != '0);
			iw2 = 1'b0;
		end else begin
			if (sp_put) begin
				iw2 = 1'b0;
				if (cc0 != '0 && cc0 <= lim) begin
					lsp2 = cc0;
					was2 = wt0;
				end
				if (EW'(cc0) < EW'(LINE_MAX + 1)) begin
					cc1 = cc0 + 1'b1;
				end
			end
			ps2 = 1'b0;
			if (tlnl_pkg::is_alnum(byte_in)) begin
				if (!iw2) begin
					iw2 = 1'b1;
					wt2 = (wt0 == tlnl_pkg::COUNT_SAT) ? wt0 : wt0 + 1'b1;
					if (cc1 < lim) begin
						wal2 = (wal0 == tlnl_pkg::COUNT_SAT) ? wal0 : wal0 + 1'b1;
					end
				end
			end else begin
				iw2 = 1'b0;
			end
			cc2 = (EW'(cc1) < EW'(LINE_MAX + 1)) ? cc1 + 1'b1 : cc1;
		end

		if (max_chars_q == '0) begin
			len_v   = (EW'(cc2) > EW'(LINE_MAX)) ? CW'(LINE_MAX) : cc2;
			words_v = wt2;
		end else if (cc2 > lim) begin
			if (lsp2 != '0) begin
				len_v   = lsp2;
				words_v = was2;
			end else begin
				len_v   = lim;
				words_v = wal2;
			end
		end else begin
			len_v   = cc2;
			words_v = wt2;
		end
		ok_v = (max_chars_q != '0) && (len_v != '0) && (words_v >= min_words_q) &&
			(words_v <= max_words_q);
	end

	always_comb begin
		len_e   = EW'(last_byte ? len_v : kept_q);
		len_e   = (cmd == tlnl_pkg::CMD_READ) ? EW'(kept_q) : len_e;
		len_sat = (len_e > EW'(tlnl_pkg::COUNT_SAT)) ? tlnl_pkg::COUNT_SAT : len_e[8:0];
	end

	always_comb begin
		sp_wr = acc_push && sp_put && (EW'(cc0) < EW'(LINE_MAX));
		ch_wr = acc_push && ch_put && (EW'(cc1) < EW'(LINE_MAX));
		buf_we.even = (sp_wr && !cc0[0]) || (ch_wr && !cc1[0]);
		buf_we.odd  = (sp_wr && cc0[0]) || (ch_wr && cc1[0]);
		if (sp_wr && !cc0[0]) begin
			waddr_even = cc0[AW-1:1];
			wdata_even = tlnl_pkg::CHAR_SPACE;
		end else begin
			waddr_even = cc1[AW-1:1];
			wdata_even = byte_in;
		end
		if (sp_wr && cc0[0]) begin
			waddr_odd = cc0[AW-1:1];
			wdata_odd = tlnl_pkg::CHAR_SPACE;
		end else begin
			waddr_odd = cc1[AW-1:1];
			wdata_odd = byte_in;
		end
		idx_w = IW'(read_index);
	end

	tlnl_text_buf #(
		.HALF_DEPTH(HALF_DEPTH),
		.HA(HA)
	) u_buf (
		.clk(clk),
		.we(buf_we),
		.waddr_even(waddr_even),
		.wdata_even(wdata_even),
		.waddr_odd(waddr_odd),
		.wdata_odd(wdata_odd),
		.re(acc_read),
		.raddr(idx_w[AW-1:1]),
		.rdata_even(rdata_even),
		.rdata_odd(rdata_odd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_words_q <= tlnl_pkg::MIN_WORDS_RST;
			max_words_q <= tlnl_pkg::MAX_WORDS_RST;
			max_chars_q <= tlnl_pkg::MAX_CHARS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tlnl_pkg::REG_MIN_WORDS: min_words_q <= cfg_data;
				tlnl_pkg::REG_MAX_WORDS: max_words_q <= cfg_data;
				tlnl_pkg::REG_MAX_CHARS: max_chars_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q   <= '0;
			ps_q   <= 1'b0;
			iw_q   <= 1'b0;
			wt_q   <= '0;
			lsp_q  <= '0;
			was_q  <= '0;
			wal_q  <= '0;
			kept_q <= '0;
			done_q <= 1'b0;
		end else if (acc_push) begin
			cc_q   <= cc2;
			ps_q   <= ps2;
			iw_q   <= iw2;
			wt_q   <= wt2;
			lsp_q  <= lsp2;
			was_q  <= was2;
			wal_q  <= wal2;
			kept_q <= last_byte ? len_v : '0;
			done_q <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_adv) begin
			v_s1 <= acc_read || (acc_push && last_byte);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && acc) begin
			kind_s1  <= acc_read ? tlnl_pkg::KIND_READ : tlnl_pkg::KIND_VERDICT;
			ok_s1    <= acc_push && ok_v;
			len_s1   <= len_sat;
			words_s1 <= acc_push ? (words_v == '0 ? '0 : words_v) : '0;
			hit_s1   <= acc_read && (EW'(read_index) < EW'(kept_q));
			odd_s1   <= read_index[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && v_s1) begin
			kind_q  <= kind_s1;
			ok_q    <= ok_s1;
			len_q   <= len_s1;
			words_q <= words_s1;
			char_q  <= hit_s1 ? (odd_s1 ? rdata_odd : rdata_even) : 8'h00;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign line_ok      = ok_q;
	assign clean_length = len_q;
	assign word_count   = words_q;
	assign char_out     = char_q;

	a_read_fields : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tlnl_pkg::KIND_READ |-> !line_ok && word_count == '0)
		else $error("read result carries verdict fields");

	a_ok_nonempty : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tlnl_pkg::KIND_VERDICT && line_ok |-> clean_length != '0
			&& char_out == 8'h00)
		else $error("passing verdict with empty line");

	a_kept_bound : assert property (@(posedge clk) disable iff (!arst_n)
		EW'(kept_q) <= EW'(LINE_MAX) && EW'(cc_q) <= EW'(LINE_MAX + 1))
		else $error("line length beyond buffer");

	a_mid_line : assert property (@(posedge clk) disable iff (!arst_n)
		acc_push && !last_byte |=> kept_q == '0 && !done_q)
		else $error("kept length not cleared during a line");

	a_single_bank : assert property (@(posedge clk) disable iff (!arst_n)
		buf_we.even && buf_we.odd |-> acc_push && sp_put)
		else $error("two buffer writes without a pending space");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for text_line_normalize_limit_core: a predictor of the line cleaner
// checks every verdict and read-data beat. Depends on tlnl_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;

	localparam int LINE_MAX     = 256;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BEATS = 800;

	typedef struct packed {
		logic       kind;
		logic       line_ok;
		logic [8:0] clean_length;
		logic [8:0] word_count;
		logic [7:0] char_out;
	} result_t;

	class line_scoreboard;
		logic [8:0]  min_words;
		logic [8:0]  max_words;
		logic [8:0]  max_chars;
		logic [7:0]  text[LINE_MAX];
		int unsigned n_clean;
		int unsigned words_all;
		int unsigned space_pos;
		int unsigned words_space;
		int unsigned words_lim;
		int unsigned kept_len;
		bit          gap_pending;
		bit          in_word;
		bit          line_closed;
		result_t     due_results[$];
		int          mismatches;

		function new();
			min_words  = tlnl_pkg::MIN_WORDS_RST;
			max_words  = tlnl_pkg::MAX_WORDS_RST;
			max_chars  = tlnl_pkg::MAX_CHARS_RST;
			mismatches = 0;
			open_line();
		endfunction

		function void open_line();
			n_clean     = 0;
			gap_pending = 0;
			in_word     = 0;
			words_all   = 0;
			space_pos   = 0;
			words_space = 0;
			words_lim   = 0;
			kept_len    = 0;
			line_closed = 0;
		endfunction

		function void queue_result(result_t r);
			due_results = {due_results, r};
		endfunction

		function void set_reg(logic [1:0] index, logic [8:0] value);
			unique case (index)
				tlnl_pkg::REG_MIN_WORDS: min_words = value;
				tlnl_pkg::REG_MAX_WORDS: max_words = value;
				tlnl_pkg::REG_MAX_CHARS: max_chars = value;
				default: ;
			endcase
		endfunction

		function int unsigned char_limit();
			return (max_chars > LINE_MAX) ? LINE_MAX : int'(max_chars);
		endfunction

		function logic [8:0] sat9(int unsigned v);
			return (v > tlnl_pkg::COUNT_SAT) ? tlnl_pkg::COUNT_SAT : 9'(v);
		endfunction

		function void store_char(logic [7:0] c);
			int unsigned p;
			int unsigned lim;
			bit          alnum;
			p = n_clean;
			lim = char_limit();
			alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
				(c >= 8'h61 && c <= 8'h7A);
			if (p < LINE_MAX)
				text[p] = c;
			if (c == tlnl_pkg::CHAR_SPACE) begin
				in_word = 0;
				if (p > 0 && p <= lim) begin
					space_pos = p;
					words_space = words_all;
				end
			end else if (alnum) begin
				if (!in_word) begin
					in_word = 1;
					words_all = sat9(words_all + 1);
					if (p < lim)
						words_lim = sat9(words_lim + 1);
				end
			end else begin
				in_word = 0;
			end
			if (n_clean < LINE_MAX + 1)
				n_clean++;
		endfunction

		function void predict_from_beat(logic c, logic [7:0] b, logic last, logic [7:0] idx);
			result_t     r;
			int unsigned lim;
			int unsigned len;
			int unsigned words;
			if (c == tlnl_pkg::CMD_READ) begin
				r.kind = tlnl_pkg::KIND_READ;
				r.line_ok = 1'b0;
				r.clean_length = sat9(kept_len);
				r.word_count = 9'd0;
				r.char_out = (idx < kept_len && idx < LINE_MAX) ? text[idx] : 8'h00;
				queue_result(r);
				return;
			end
			if (line_closed)
				open_line();
			if (b < 8'h20 || b == tlnl_pkg::CHAR_DEL || b == tlnl_pkg::CHAR_SPACE) begin
				if (n_clean > 0)
					gap_pending = 1;
				in_word = 0;
			end else begin
				if (gap_pending) begin
					store_char(tlnl_pkg::CHAR_SPACE);
					gap_pending = 0;
				end
				store_char(b);
			end
			if (!last)
				return;
			lim = char_limit();
			if (max_chars == 0) begin
				len = (n_clean > LINE_MAX) ? LINE_MAX : n_clean;
				words = words_all;
			end else if (n_clean > lim) begin
				if (space_pos > 0) begin
					len = space_pos;
					words = words_space;
				end else begin
					len = lim;
					words = words_lim;
				end
			end else begin
				len = n_clean;
				words = words_all;
			end
			kept_len = len;
			line_closed = 1;
			r.kind = tlnl_pkg::KIND_VERDICT;
			r.line_ok = (max_chars != 0 && len > 0 && words >= min_words && words <= max_words);
			r.clean_length = sat9(len);
			r.word_count = sat9(words);
			r.char_out = 8'h00;
			queue_result(r);
		endfunction

		function void check_result(logic k, logic ok, logic [8:0] len, logic [8:0] words,
				logic [7:0] ch);
			result_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: kind=%0d ok=%0d len=%0d words=%0d char=%02h",
						k, ok, len, words, ch);
				return;
			end
			want = due_results.pop_front();
			if (k !== want.kind || ok !== want.line_ok || len !== want.clean_length ||
					words !== want.word_count || ch !== want.char_out) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result mismatch: expected kind=%0d ok=%0d len=%0d words=%0d ",
						"char=%02h, got kind=%0d ok=%0d len=%0d words=%0d char=%02h"},
						want.kind, want.line_ok, want.clean_length, want.word_count,
						want.char_out, k, ok, len, words, ch);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       cmd;
	logic [7:0] byte_in;
	logic       last_byte;
	logic [7:0] read_index;
	logic       out_valid;
	logic       out_ready;
	logic       kind;
	logic       line_ok;
	logic [8:0] clean_length;
	logic [8:0] word_count;
	logic [7:0] char_out;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	line_scoreboard scoreboard;
	logic [7:0]     line_bytes[$];
	int             beats_sent;
	int             cycle_count = 0;
	bit             in_calm;
	bit             out_calm;

	text_line_normalize_limit_core #(
		.LINE_MAX(LINE_MAX)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.byte_in     (byte_in),
		.last_byte   (last_byte),
		.read_index  (read_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.line_ok     (line_ok),
		.clean_length(clean_length),
		.word_count  (word_count),
		.char_out    (char_out),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			scoreboard.check_result(kind, line_ok, clean_length, word_count, char_out);
	end

	initial begin : receiver
		int stall;
		out_ready = 1'b0;
		out_calm = 1'b0;
		forever begin
			if ($urandom_range(0, 39) == 0)
				out_calm = ~out_calm;
			stall = out_calm ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	function automatic void append_byte(input logic [7:0] b);
		line_bytes = {line_bytes, b};
	endfunction

	task automatic send_beat(input logic c, input logic [7:0] b, input logic last,
			input logic [7:0] idx);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		byte_in <= b;
		last_byte <= last;
		read_index <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		scoreboard.predict_from_beat(c, b, last, idx);
		beats_sent++;
	endtask

	task automatic send_push(input logic [7:0] b, input logic last);
		send_beat(tlnl_pkg::CMD_PUSH, b, last, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_read(input logic [7:0] idx);
		send_beat(tlnl_pkg::CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			idx);
	endtask

	// The block is idle once nothing is due and a push without result has left the pipeline.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (scoreboard.due_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [8:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		scoreboard.set_reg(index, value);
	endtask

	task automatic write_settings(input logic [8:0] lo, input logic [8:0] hi,
			input logic [8:0] lim);
		write_reg(tlnl_pkg::REG_MIN_WORDS, lo);
		write_reg(tlnl_pkg::REG_MAX_WORDS, hi);
		write_reg(tlnl_pkg::REG_MAX_CHARS, lim);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 2))
			0: return 8'($urandom_range(8'h30, 8'h39));
			1: return 8'($urandom_range(8'h41, 8'h5A));
			default: return 8'($urandom_range(8'h61, 8'h7A));
		endcase
	endfunction

	function automatic logic [7:0] gap_char();
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(0, 31));
			1: return tlnl_pkg::CHAR_DEL;
			default: return tlnl_pkg::CHAR_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] odd_char();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(33, 47));
	endfunction

	function automatic logic [8:0] pick_limit();
		case ($urandom_range(0, 5))
			0: return 9'd0;
			1: return 9'd1;
			2: return 9'd256;
			3: return 9'($urandom_range(1, 256));
			default: return 9'($urandom_range(2, 40));
		endcase
	endfunction

	task automatic build_line(input int target);
		line_bytes.delete();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) append_byte(gap_char());
		while (line_bytes.size() < target) begin
			repeat ($urandom_range(1, 8))
				append_byte(($urandom_range(0, 9) == 0) ? odd_char() : word_char());
			repeat ($urandom_range(1, 3)) append_byte(gap_char());
		end
		if ($urandom_range(0, 1))
			append_byte(word_char());
	endtask

	task automatic play_bytes(input int from, input int upto);
		int i;
		for (i = from; i < upto; i++) begin
			if ($urandom_range(0, 24) == 0)
				send_read(8'($urandom_range(0, 255)));
			send_push(line_bytes[i], i == line_bytes.size() - 1);
		end
	endtask

	task automatic read_back();
		int unsigned k;
		repeat ($urandom_range(0, 4)) begin
			k = scoreboard.kept_len;
			if ($urandom_range(0, 3) == 0)
				send_read(8'($urandom_range(0, 255)));
			else
				send_read(8'($urandom_range(0, (k < 255) ? k + 1 : 255)));
		end
	endtask

	initial begin : stimulus
		int          phase_end;
		int          cut;
		int          random_end;
		logic [8:0]  lo;
		logic [8:0]  hi;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = tlnl_pkg::CMD_PUSH;
		byte_in = 8'h00;
		last_byte = 1'b0;
		read_index = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = tlnl_pkg::REG_MIN_WORDS;
		cfg_data = 9'd0;
		beats_sent = 0;
		in_calm = 1'b0;
		scoreboard = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_read(8'd0);
		send_push(8'h00, 1'b0);
		send_push(8'h41, 1'b0);
		send_push(tlnl_pkg::CHAR_DEL, 1'b0);
		send_push(tlnl_pkg::CHAR_SPACE, 1'b0);
		send_push(8'h7A, 1'b0);
		send_push(8'hFF, 1'b0);
		send_push(8'h39, 1'b0);
		send_push(8'h1F, 1'b0);
		send_push(8'h80, 1'b0);
		send_push(tlnl_pkg::CHAR_SPACE, 1'b1);
		send_read(8'd0);
		send_read(8'd6);
		send_read(8'd7);
		send_read(8'd255);
		send_push(8'h30, 1'b0);
		send_read(8'd0);
		send_push(8'h5A, 1'b1);
		send_push(8'h09, 1'b1);
		settle();
		write_settings(9'd0, 9'd0, 9'd0);
		send_push(8'h61, 1'b0);
		send_push(tlnl_pkg::CHAR_SPACE, 1'b0);
		send_push(8'h62, 1'b1);
		settle();
		write_settings(9'd1, 9'd256, 9'd2);
		send_push(8'h61, 1'b0);
		send_push(tlnl_pkg::CHAR_SPACE, 1'b0);
		send_push(8'h62, 1'b1);

		random_end = beats_sent + RANDOM_BEATS;
		while (beats_sent < random_end) begin
			settle();
			case ($urandom_range(0, 4))
				0: lo = 9'd0;
				1: lo = 9'd256;
				default: lo = 9'($urandom_range(0, 4));
			endcase
			case ($urandom_range(0, 5))
				0: hi = 9'd0;
				1: hi = 9'd256;
				2: hi = 9'd255;
				default: hi = 9'($urandom_range(1, 10));
			endcase
			write_settings(lo, hi, pick_limit());
			phase_end = beats_sent + $urandom_range(50, 120);
			while (beats_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0)
					in_calm = ~in_calm;
				case ($urandom_range(0, 19))
					0: begin
						line_bytes.delete();
						repeat ($urandom_range(1, 30))
							append_byte(8'($urandom_range(0, 255)));
					end
					1: build_line($urandom_range(200, 300));
					2: begin
						line_bytes.delete();
						repeat ($urandom_range(1, 4)) append_byte(gap_char());
					end
					default: build_line($urandom_range(1, 40));
				endcase
				if ($urandom_range(0, 9) == 0 && line_bytes.size() > 2) begin
					cut = line_bytes.size() / 2;
					play_bytes(0, cut);
					settle();
					write_reg(tlnl_pkg::REG_MAX_CHARS, pick_limit());
					cfg_valid <= 1'b0;
					play_bytes(cut, line_bytes.size());
				end else begin
					play_bytes(0, line_bytes.size());
				end
				read_back();
			end
		end

		settle();
		if (scoreboard.mismatches == 0 && scoreboard.due_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
